// ===== src/amtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amtd_pkg
// Shared widths, codes, reset values and lane/merge structures for the
// accelerometer motion tamper detector.
// ----------------------------------------------------------------------------
package amtd_pkg;

   // Fraction bits of the baseline fixed-point format.
   localparam int BASE_FRAC_BITS = 16;

   // Raw sensor word and sample formats.
   localparam int WORD_W  = 16;
   localparam int COUNT_W = 12;
   localparam int COUNT_LO = WORD_W - COUNT_W;
   localparam int MG_SHIFT = 4;
   localparam int MG_W    = COUNT_W + MG_SHIFT;

   // Baseline, difference and rounded-difference widths.
   localparam int BASE_W = MG_W + BASE_FRAC_BITS;
   localparam int DIFF_W = BASE_W + 1;
   localparam int RND_W  = MG_W + 1;
   localparam int SQ_W   = 2 * RND_W - 1;

   // Deviation, limit and gain widths.
   localparam int DEV_W   = 34;
   localparam int LIMIT_W = 34;
   localparam int GAIN_W  = 12;
   localparam int GAIN_SHIFT = 12;
   localparam int PROD_W  = DIFF_W + GAIN_W + 1;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_LO = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - CSR_IDX_LO;

   // Register reset values.
   localparam logic [LIMIT_W-1:0] TRIP_LIMIT_RESET   = LIMIT_W'(2250000);
   localparam logic [LIMIT_W-1:0] SETTLE_LIMIT_RESET = LIMIT_W'(100000);
   localparam logic [GAIN_W-1:0]  ADAPT_GAIN_RESET   = GAIN_W'(41);

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TRIP_LIMIT   = 2'd0,
      REG_SETTLE_LIMIT = 2'd1,
      REG_ADAPT_GAIN   = 2'd2
   } reg_index_type;

   // Operation codes.
   localparam logic OP_CHECK   = 1'b0;
   localparam logic OP_CAPTURE = 1'b1;

   // What one axis lane hands to the merge stage and the state update.
   typedef struct packed {
      logic [SQ_W-1:0]          sq;
      logic signed [BASE_W-1:0] base_adapted;
      logic signed [BASE_W-1:0] sample_fix;
   } lane_result_type;

   // Decision of the merge stage.
   typedef struct packed {
      logic [DEV_W-1:0] dev;
      logic             trip_hit;
      logic             settle_hit;
   } decision_type;

endpackage
`default_nettype wire

// ===== src/accel_motion_tamper_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is presented in the cycle after its request transaction is accepted.
// Throughput: one sample per cycle; the baseline update finishes in the accepting cycle,
// so the next sample sees it at once.
// A waiting result holds off new requests; one is taken in the cycle that result is taken.
// Reset (synchronous, active high) clears the armed and trip flags, the baselines and
// the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
// accel_motion_tamper_detector_unit
// Three-axis motion tamper detector with an exponentially averaged baseline:
// one lane per axis, a merge stage for the deviation, and the state update.
// ----------------------------------------------------------------------------
module accel_motion_tamper_detector_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata fields from bit 0: x_word[15:0], y_word[15:0], z_word[15:0].
   input  wire logic [47:0]                       req_tdata,
   // tuser fields from bit 0: operation[0].
   input  wire logic                              req_tuser,
   // Response stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata fields from bit 0: tripped[0], armed[0], deviation_sq[33:0],
   // baseline_moved[0], zero fill[2:0].
   output logic [39:0]                            rsp_tdata,
   // Configuration port.
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [amtd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [amtd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [amtd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int W = amtd_pkg::WORD_W;

   // Configuration registers.
   logic [amtd_pkg::LIMIT_W-1:0] trip_limit_ff;
   logic [amtd_pkg::LIMIT_W-1:0] settle_limit_ff;
   logic [amtd_pkg::GAIN_W-1:0]  adapt_gain_ff;

   // Detector state.
   logic signed [amtd_pkg::BASE_W-1:0] base_x_ff, base_x_in;
   logic signed [amtd_pkg::BASE_W-1:0] base_y_ff, base_y_in;
   logic signed [amtd_pkg::BASE_W-1:0] base_z_ff, base_z_in;
   logic                               trip_ff, trip_in;
   logic                               armed_ff, armed_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [amtd_pkg::DEV_W-1:0]   out_dev_ff, out_dev_in;
   logic                         out_moved_ff, out_moved_in;
   logic                         out_trip_ff;
   logic                         out_armed_ff;

   logic                         accept;
   logic                         csr_write;
   amtd_pkg::reg_index_type      csr_index;
   amtd_pkg::lane_result_type    lane_x, lane_y, lane_z;
   amtd_pkg::decision_type       decision;

   // Axis lanes.
   amtd_lane u_lane_x (
      .word   (req_tdata[W-1:0]),
      .base   (base_x_ff),
      .gain   (adapt_gain_ff),
      .result (lane_x)
   );

   amtd_lane u_lane_y (
      .word   (req_tdata[2*W-1:W]),
      .base   (base_y_ff),
      .gain   (adapt_gain_ff),
      .result (lane_y)
   );

   amtd_lane u_lane_z (
      .word   (req_tdata[3*W-1:2*W]),
      .base   (base_z_ff),
      .gain   (adapt_gain_ff),
      .result (lane_z)
   );

   // Deviation and limit comparisons.
   amtd_merge u_merge (
      .sq_x         (lane_x.sq),
      .sq_y         (lane_y.sq),
      .sq_z         (lane_z.sq),
      .trip_limit   (trip_limit_ff),
      .settle_limit (settle_limit_ff),
      .decision     (decision)
   );

   // A request transaction is taken whenever the output register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Next state of the detector and the result of the accepted transaction.
   always_comb begin
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      base_z_in    = base_z_ff;
      trip_in      = trip_ff;
      armed_in     = armed_ff;
      out_dev_in   = '0;
      out_moved_in = 1'b0;
      if (req_tuser == amtd_pkg::OP_CAPTURE) begin
         base_x_in = lane_x.sample_fix;
         base_y_in = lane_y.sample_fix;
         base_z_in = lane_z.sample_fix;
         armed_in  = 1'b1;
         trip_in   = 1'b0;
      end else if (armed_ff && !trip_ff) begin
         out_dev_in = decision.dev;
         if (decision.trip_hit) begin
            trip_in = 1'b1;
         end
         if (decision.settle_hit) begin
            base_x_in    = lane_x.base_adapted;
            base_y_in    = lane_y.base_adapted;
            base_z_in    = lane_z.base_adapted;
            out_moved_in = 1'b1;
         end
      end
   end

   // Output valid: set by an accepted transaction, cleared when the result is taken.
   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and baselines.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         trip_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         base_z_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            trip_ff   <= trip_in;
            armed_ff  <= armed_in;
            base_x_ff <= base_x_in;
            base_y_ff <= base_y_in;
            base_z_ff <= base_z_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_dev_ff   <= out_dev_in;
         out_moved_ff <= out_moved_in;
         out_trip_ff  <= trip_in;
         out_armed_ff <= armed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, out_moved_ff, out_dev_ff, out_armed_ff, out_trip_ff};

   // Configuration port: registers sit at 8-byte strides.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = amtd_pkg::reg_index_type'(csr_paddr[amtd_pkg::CSR_ADDR_W-1:
                                                            amtd_pkg::CSR_IDX_LO]);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         trip_limit_ff   <= amtd_pkg::TRIP_LIMIT_RESET;
         settle_limit_ff <= amtd_pkg::SETTLE_LIMIT_RESET;
         adapt_gain_ff   <= amtd_pkg::ADAPT_GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            amtd_pkg::REG_TRIP_LIMIT: begin
               trip_limit_ff <= csr_pwdata[amtd_pkg::LIMIT_W-1:0];
            end
            amtd_pkg::REG_SETTLE_LIMIT: begin
               settle_limit_ff <= csr_pwdata[amtd_pkg::LIMIT_W-1:0];
            end
            amtd_pkg::REG_ADAPT_GAIN: begin
               adapt_gain_ff <= csr_pwdata[amtd_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration register reads.
   always_comb begin
      unique case (csr_index)
         amtd_pkg::REG_TRIP_LIMIT: begin
            csr_prdata = amtd_pkg::CSR_DATA_W'(trip_limit_ff);
         end
         amtd_pkg::REG_SETTLE_LIMIT: begin
            csr_prdata = amtd_pkg::CSR_DATA_W'(settle_limit_ff);
         end
         amtd_pkg::REG_ADAPT_GAIN: begin
            csr_prdata = amtd_pkg::CSR_DATA_W'(adapt_gain_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/amtd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amtd_lane
// One axis lane: converts the raw word to fixed-point milli-g, forms the
// difference to the baseline, its rounded square and the adapted baseline.
// ----------------------------------------------------------------------------
module amtd_lane (
   input  wire logic [amtd_pkg::WORD_W-1:0]        word,
   input  wire logic signed [amtd_pkg::BASE_W-1:0] base,
   input  wire logic [amtd_pkg::GAIN_W-1:0]        gain,
   output amtd_pkg::lane_result_type               result
);

   logic signed [amtd_pkg::COUNT_W-1:0] count;
   logic signed [amtd_pkg::MG_W-1:0]    sample_mg;
   logic signed [amtd_pkg::BASE_W-1:0]  sample_fix;
   logic signed [amtd_pkg::DIFF_W-1:0]  diff_fix;
   logic signed [amtd_pkg::DIFF_W-1:0]  diff_half;
   logic signed [amtd_pkg::DIFF_W-1:0]  diff_floor;
   logic signed [amtd_pkg::RND_W-1:0]   diff_mg;
   logic signed [2*amtd_pkg::RND_W-1:0] sq_full;
   logic signed [amtd_pkg::PROD_W-1:0]  prod;
   logic signed [amtd_pkg::PROD_W-1:0]  prod_rnd;
   logic signed [amtd_pkg::PROD_W-1:0]  step;

   // The top bits of the left-justified word are a signed count; times 16 is milli-g.
   assign count      = $signed(word[amtd_pkg::WORD_W-1:amtd_pkg::COUNT_LO]);
   assign sample_mg  = {count, amtd_pkg::MG_SHIFT'(0)};
   assign sample_fix = {sample_mg, amtd_pkg::BASE_FRAC_BITS'(0)};

   // Fixed-point difference to the baseline.
   assign diff_fix = amtd_pkg::DIFF_W'(sample_fix) - amtd_pkg::DIFF_W'(base);

   // Round half up to whole milli-g, then square.
   assign diff_half  = diff_fix + amtd_pkg::DIFF_W'(1 << (amtd_pkg::BASE_FRAC_BITS - 1));
   assign diff_floor = diff_half >>> amtd_pkg::BASE_FRAC_BITS;
   assign diff_mg    = diff_floor[amtd_pkg::RND_W-1:0];
   assign sq_full    = diff_mg * diff_mg;

   // Exponential average step: round(diff * gain / 4096), ties rounded toward plus.
   assign prod     = amtd_pkg::PROD_W'(diff_fix) * amtd_pkg::PROD_W'($signed({1'b0, gain}));
   assign prod_rnd = prod + amtd_pkg::PROD_W'(1 << (amtd_pkg::GAIN_SHIFT - 1));
   assign step     = prod_rnd >>> amtd_pkg::GAIN_SHIFT;

   assign result.sq           = sq_full[amtd_pkg::SQ_W-1:0];
   assign result.base_adapted = base + step[amtd_pkg::BASE_W-1:0];
   assign result.sample_fix   = sample_fix;

endmodule
`default_nettype wire

// ===== src/amtd_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amtd_merge
// Merge stage: sums the three lane squares into the deviation and compares
// it against the trip and settle limits.
// ----------------------------------------------------------------------------
module amtd_merge (
   input  wire logic [amtd_pkg::SQ_W-1:0]    sq_x,
   input  wire logic [amtd_pkg::SQ_W-1:0]    sq_y,
   input  wire logic [amtd_pkg::SQ_W-1:0]    sq_z,
   input  wire logic [amtd_pkg::LIMIT_W-1:0] trip_limit,
   input  wire logic [amtd_pkg::LIMIT_W-1:0] settle_limit,
   output amtd_pkg::decision_type            decision
);

   logic [amtd_pkg::DEV_W-1:0] dev;

   // The sum of three squares stays within the deviation width.
   assign dev = amtd_pkg::DEV_W'(sq_x) + amtd_pkg::DEV_W'(sq_y) + amtd_pkg::DEV_W'(sq_z);

   assign decision.dev        = dev;
   assign decision.trip_hit   = (dev > trip_limit);
   assign decision.settle_hit = (dev < settle_limit);

endmodule
`default_nettype wire

// ===== dv/tb_accel_motion_tamper_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_motion_tamper_detector_unit
// Self-checking bench for the motion tamper detector. A short table of
// directed samples and register writes is followed by phases of random
// samples, each phase under its own limits and averaging gain. Most samples
// stay near a captured rest position, so the baseline keeps adapting. Some
// move far enough to trip the detector, and a few are plain noise. Every
// response is checked against a table entry or a predictor with its own
// baseline, flags and register copies. Streams stall at random outside phase 3.
// ----------------------------------------------------------------------------
module tb_accel_motion_tamper_detector_unit;
   import amtd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned DRAIN_LIMIT = 1000;
   localparam int unsigned PHASES = 6;
   localparam int unsigned SAMPLES_PER_PHASE = 92;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};
   localparam logic [DEV_W-1:0] DEV_MAX = DEV_W'(64'd12878611200);
   localparam longint FIX_ONE = longint'(1) <<< BASE_FRAC_BITS;

   // One response transaction, split into its fields.
   typedef struct packed {
      logic             tripped;
      logic             armed;
      logic [DEV_W-1:0] deviation;
      logic             moved;
   } tamper_verdict_type;

   typedef enum logic {PLAN_SAMPLE, PLAN_REGISTER} plan_kind_type;

   // One row of the directed plan: a sample or a register write.
   typedef struct {
      plan_kind_type      kind;
      logic               op;
      logic [47:0]        words;
      bit                 typed;
      tamper_verdict_type want;
      reg_index_type      reg_idx;
      logic [63:0]        reg_value;
   } plan_row_type;

   // Clock, reset and the ports of the block.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state and its copy of the registers.
   logic signed [BASE_W-1:0] baseline_fix [3] = '{default: '0};
   logic                     trip_latched = 1'b0;
   logic                     armed_latched = 1'b0;
   logic [LIMIT_W-1:0]       trip_limit = TRIP_LIMIT_RESET;
   logic [LIMIT_W-1:0]       settle_limit = SETTLE_LIMIT_RESET;
   logic [GAIN_W-1:0]        gain_weight = ADAPT_GAIN_RESET;

   tamper_verdict_type expected_verdicts [$];
   plan_row_type       directed_plan [$];
   bit                 steady = 1'b0;

   int unsigned items_sent = 0;
   int unsigned captures_sent = 0;
   int unsigned results_seen = 0;
   int unsigned trips_seen = 0;
   int unsigned moves_seen = 0;
   int unsigned mismatches = 0;
   int unsigned registers_written = 0;
   int unsigned cycle_count = 0;

   accel_motion_tamper_detector_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // A 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_verdicts.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Decide whether a side pauses this cycle; never during a steady phase.
   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 38);
   endfunction

   // Work out the response to one sample and advance the predictor state.
   function automatic tamper_verdict_type predict_motion(input logic op,
                                                         input logic [47:0] words);
      tamper_verdict_type        verdict;
      logic signed [COUNT_W-1:0] count;
      longint                    sample_fix [3];
      longint                    diff [3];
      longint                    rounded;
      longint                    dev_sum;
      longint                    step;
      verdict = '0;
      dev_sum = 0;
      for (int a = 0; a < 3; a++) begin
         count = words[16*a+COUNT_LO +: COUNT_W];
         sample_fix[a] = longint'(count) * 16 * FIX_ONE;
      end
      if (op == OP_CAPTURE) begin
         for (int a = 0; a < 3; a++) baseline_fix[a] = BASE_W'(sample_fix[a]);
         armed_latched = 1'b1;
         trip_latched = 1'b0;
      end else if (armed_latched && !trip_latched) begin
         // Distance in whole milli-g, rounded half up on each axis.
         for (int a = 0; a < 3; a++) begin
            diff[a] = sample_fix[a] - longint'(baseline_fix[a]);
            rounded = (diff[a] + FIX_ONE / 2) >>> BASE_FRAC_BITS;
            dev_sum += rounded * rounded;
         end
         if (dev_sum > longint'(trip_limit)) trip_latched = 1'b1;
         // The average moves on the unrounded difference.
         if (dev_sum < longint'(settle_limit)) begin
            for (int a = 0; a < 3; a++) begin
               step = (diff[a] * longint'(gain_weight) + 2048) >>> GAIN_SHIFT;
               baseline_fix[a] = BASE_W'(longint'(baseline_fix[a]) + step);
            end
            verdict.moved = 1'b1;
         end
         verdict.deviation = DEV_W'(dev_sum);
      end
      verdict.tripped = trip_latched;
      verdict.armed = armed_latched;
      return verdict;
   endfunction

   function automatic plan_row_type plan_sample(input logic op, input logic [15:0] x,
                                                input logic [15:0] y, input logic [15:0] z);
      plan_row_type row;
      row.kind = PLAN_SAMPLE;
      row.op = op;
      row.words = {z, y, x};
      row.typed = 1'b0;
      row.want = '0;
      row.reg_idx = REG_TRIP_LIMIT;
      row.reg_value = '0;
      return row;
   endfunction

   function automatic plan_row_type plan_typed(input logic op, input logic [15:0] x,
                                               input logic [15:0] y, input logic [15:0] z,
                                               input logic tripped, input logic armed,
                                               input logic [DEV_W-1:0] deviation,
                                               input logic moved);
      plan_row_type row;
      row = plan_sample(op, x, y, z);
      row.typed = 1'b1;
      row.want = '{tripped: tripped, armed: armed, deviation: deviation, moved: moved};
      return row;
   endfunction

   function automatic plan_row_type plan_register(input reg_index_type idx,
                                                  input logic [63:0] value);
      plan_row_type row;
      row = plan_sample(OP_CHECK, '0, '0, '0);
      row.kind = PLAN_REGISTER;
      row.reg_idx = idx;
      row.reg_value = value;
      return row;
   endfunction

   // A raw axis word near a center count, with random ignored low bits.
   function automatic logic [15:0] axis_word(input logic [COUNT_W-1:0] center,
                                             input int unsigned spread);
      logic [COUNT_W-1:0] count;
      count = center + COUNT_W'($urandom_range(0, 2 * spread) - spread);
      return {count, 4'($urandom_range(0, 15))};
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit(input int unsigned typical_hi);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return LIMIT_MAX;
      if (roll == 2) return {2'($urandom_range(0, 3)), 32'($urandom)};
      return LIMIT_W'($urandom_range(0, typical_hi));
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll < 6) return GAIN_W'($urandom_range(0, 4095));
      return GAIN_W'($urandom_range(8, 200));
   endfunction

   // Offer one sample and record its expected response once it is taken.
   task automatic send_sample(input plan_row_type row);
      tamper_verdict_type predicted;
      @(negedge clock);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= row.op;
      req_tdata <= row.words;
      do @(posedge clock); while (!req_tready);
      predicted = predict_motion(row.op, row.words);
      expected_verdicts.push_back(row.typed ? row.want : predicted);
      items_sent++;
      if (row.op == OP_CAPTURE) captures_sent++;
   endtask

   // Let every response drain, then write one register.
   task automatic write_register(input reg_index_type idx, input logic [63:0] value);
      do begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end while (expected_verdicts.size() != 0);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << CSR_IDX_LO;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TRIP_LIMIT:   trip_limit = value[LIMIT_W-1:0];
         REG_SETTLE_LIMIT: settle_limit = value[LIMIT_W-1:0];
         REG_ADAPT_GAIN:   gain_weight = value[GAIN_W-1:0];
         default: ;
      endcase
      registers_written++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Response side stalls at random.
   always @(negedge clock) begin
      rsp_tready <= !take_break();
   end

   // Compare every response transaction with the oldest expectation.
   always @(posedge clock) begin : response_check
      tamper_verdict_type got;
      tamper_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.tripped = rsp_tdata[0];
         got.armed = rsp_tdata[1];
         got.deviation = rsp_tdata[35:2];
         got.moved = rsp_tdata[36];
         results_seen++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response tripped=%0b armed=%0b dev=%0d moved=%0b",
                        got.tripped, got.armed, got.deviation, got.moved);
         end else begin
            want = expected_verdicts.pop_front();
            if (got.tripped !== want.tripped || got.armed !== want.armed ||
                got.deviation !== want.deviation || got.moved !== want.moved) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: response %0d expected tripped=%0b armed=%0b dev=%0d moved=%0b",
                           results_seen, want.tripped, want.armed, want.deviation,
                           want.moved);
                  $display("       got tripped=%0b armed=%0b dev=%0d moved=%0b",
                           got.tripped, got.armed, got.deviation, got.moved);
               end
            end
            if (got.tripped) trips_seen++;
            if (got.moved) moves_seen++;
         end
      end
   end

   // Reset, the directed plan, random phases, then the drain and the verdict.
   initial begin : stimulus
      logic [COUNT_W-1:0] center [3];
      logic [15:0]        axis [3];
      logic               op;
      int unsigned        roll;
      int unsigned        spread;
      int unsigned        waited;
      int unsigned        leftovers;

      directed_plan = {
         // Not armed yet: ignored.
         plan_typed(OP_CHECK, 16'h7FF0, 16'h8000, 16'h1234, 1'b0, 1'b0, '0, 1'b0),
         plan_typed(OP_CAPTURE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, '0, 1'b0),
         // Low nibble is ignored, so this sits on the baseline.
         plan_typed(OP_CHECK, 16'h0000, 16'h000F, 16'h0007, 1'b0, 1'b1, '0, 1'b1),
         plan_sample(OP_CHECK, 16'h0010, 16'hFFF0, 16'h0020),
         // Between the settle and trip limits.
         plan_sample(OP_CHECK, 16'h0140, 16'h0000, 16'h0000),
         plan_sample(OP_CHECK, 16'h7FF0, 16'h7FF0, 16'h7FF0),
         // Already tripped: ignored.
         plan_typed(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, '0, 1'b0),
         plan_typed(OP_CAPTURE, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1, '0, 1'b0),
         // Largest possible distance.
         plan_typed(OP_CHECK, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, DEV_MAX, 1'b0),
         plan_typed(OP_CAPTURE, 16'h7FF0, 16'h800F, 16'h0000, 1'b0, 1'b1, '0, 1'b0),
         plan_register(REG_TRIP_LIMIT, 64'(LIMIT_MAX)),
         plan_register(REG_SETTLE_LIMIT, 64'(LIMIT_MAX)),
         plan_register(REG_ADAPT_GAIN, 64'd0),
         // Zero gain still reports an adaptation.
         plan_sample(OP_CHECK, 16'h7FE0, 16'h8010, 16'h0010),
         plan_sample(OP_CHECK, 16'h7FE0, 16'h8010, 16'h0010),
         plan_register(REG_ADAPT_GAIN, 64'd4095),
         plan_sample(OP_CHECK, 16'h8000, 16'h7FF0, 16'h8000),
         // Trip and adaptation on the same sample.
         plan_register(REG_TRIP_LIMIT, 64'd0),
         plan_sample(OP_CHECK, 16'h1240, 16'hEDB0, 16'h0400),
         plan_typed(OP_CAPTURE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, '0, 1'b0),
         // Zero distance neither trips nor adapts with both limits at zero.
         plan_register(REG_SETTLE_LIMIT, 64'd0),
         plan_typed(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, '0, 1'b0),
         plan_register(REG_TRIP_LIMIT, 64'(TRIP_LIMIT_RESET)),
         plan_register(REG_SETTLE_LIMIT, 64'(SETTLE_LIMIT_RESET)),
         plan_register(REG_ADAPT_GAIN, 64'(ADAPT_GAIN_RESET))
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == PLAN_REGISTER)
            write_register(directed_plan[i].reg_idx, directed_plan[i].reg_value);
         else
            send_sample(directed_plan[i]);
      end

      // Random phases, each under its own register settings.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         if (phase == 1) begin
            write_register(REG_TRIP_LIMIT, 64'd0);
            write_register(REG_SETTLE_LIMIT, 64'(LIMIT_MAX));
            write_register(REG_ADAPT_GAIN, 64'd4095);
         end else if (phase == 2) begin
            write_register(REG_TRIP_LIMIT, 64'(LIMIT_MAX));
            write_register(REG_SETTLE_LIMIT, 64'd0);
            write_register(REG_ADAPT_GAIN, 64'd0);
         end else begin
            write_register(REG_TRIP_LIMIT, 64'(pick_limit(5000000)));
            write_register(REG_SETTLE_LIMIT, 64'(pick_limit(300000)));
            write_register(REG_ADAPT_GAIN, 64'(pick_gain()));
         end
         steady = (phase == 3);
         for (int a = 0; a < 3; a++) center[a] = COUNT_W'($urandom);
         for (int unsigned n = 0; n < SAMPLES_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               // Noise: any operation, any words.
               op = 1'($urandom);
               for (int a = 0; a < 3; a++) axis[a] = 16'($urandom);
            end else if ((!armed_latched || trip_latched) ? (roll < 45) : (roll < 8)) begin
               // Capture a rest position, often a new one.
               op = OP_CAPTURE;
               if ($urandom_range(0, 1))
                  for (int a = 0; a < 3; a++) center[a] = COUNT_W'($urandom);
               for (int a = 0; a < 3; a++) axis[a] = axis_word(center[a], 2);
            end else begin
               // Check near the rest position, with occasional large moves.
               op = OP_CHECK;
               for (int a = 0; a < 3; a++) begin
                  roll = $urandom_range(0, 99);
                  spread = (roll < 70) ? 6 : (roll < 92) ? 150 : 2048;
                  axis[a] = axis_word(center[a], spread);
               end
            end
            send_sample(plan_sample(op, axis[0], axis[1], axis[2]));
         end
         steady = 1'b0;
      end

      // Wait for the last responses, within a bound.
      waited = 0;
      do begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         waited++;
      end while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT);
      repeat (4) @(posedge clock);
      leftovers = expected_verdicts.size();
      if (leftovers != 0) $display("ERROR: %0d responses never arrived.", leftovers);

      $display("Ran %0d samples (%0d captures) and %0d register writes in %0d cycles.",
               items_sent, captures_sent, registers_written, cycle_count);
      $display("Checked %0d responses: %0d tripped, %0d adapted, %0d mismatches.",
               results_seen, trips_seen, moves_seen, mismatches);
      if (mismatches == 0 && leftovers == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
